@@ rtl/qsu_pkg.sv @@
`default_nettype none
package qsu_pkg;

    // decoder modes
    typedef enum logic [2:0] {
        MODE_ENDED  = 3'd0,
        MODE_NORMAL = 3'd1,
        MODE_ESC    = 3'd2,
        MODE_ZERO   = 3'd3,
        MODE_OCT    = 3'd4,
        MODE_HEX    = 3'd5
    } t_mode;

    // one decoded result as held in the output buffer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
        logic       last_result;
    } t_res;

    // what a plain byte gives
    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       end_of_string;
    } t_plain;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_N_LO   = 8'h6E;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_T_LO   = 8'h74;
    localparam logic [7:0] CH_X_LO   = 8'h78;

    // digit counts that close a numeric escape
    localparam logic [1:0] OCT_DIGITS = 2'd3;
    localparam logic [1:0] HEX_DIGITS = 2'd2;

    // result of an ordinary byte inside the string
    function automatic t_plain plain_emit(input logic [7:0] b);
        t_plain p;
        p = '0;
        if (b == CH_NUL || b == CH_QUOTE) begin
            p.emit          = 1'b1;
            p.end_of_string = 1'b1;
        end else if (b != CH_BSLASH) begin
            p.emit     = 1'b1;
            p.out_byte = b;
        end
        return p;
    endfunction

    // mode after an ordinary byte inside the string
    function automatic t_mode plain_mode(input logic [7:0] b);
        t_mode m;
        m = MODE_NORMAL;
        if (b == CH_NUL || b == CH_QUOTE) begin
            m = MODE_ENDED;
        end else if (b == CH_BSLASH) begin
            m = MODE_ESC;
        end
        return m;
    endfunction

    // hex digit value, msb set when the byte is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = '0;
        if (b >= CH_0 && b <= CH_9) begin
            d = {1'b1, b[3:0]};
        end else if ((b >= CH_A_LO && b <= CH_F_LO) || (b >= CH_A_UP && b <= CH_F_UP)) begin
            d = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return d;
    endfunction

endpackage
`default_nettype wire

@@ rtl/qsu_if.sv @@
`default_nettype none
// raw byte channel
interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_opening;

    modport source (output valid, output in_byte, output is_opening, input ready);
    modport sink   (input valid, input in_byte, input is_opening, output ready);
endinterface

// decoded byte channel
interface qsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       last_result;

    modport source (output valid, output out_byte, output end_of_string,
                    output last_result, input ready);
    modport sink   (input valid, input out_byte, input end_of_string,
                    input last_result, output ready);
endinterface
`default_nettype wire

@@ rtl/quoted_string_unescape_core.sv @@
`default_nettype none
// channel  | dir | payload                                  | handshake
// i_in     | in  | in_byte[7:0], is_opening                 | valid/ready
// o_out    | out | out_byte[7:0], end_of_string, last_result | valid/ready
//
// one raw byte is taken per cycle while the buffer has room; results go from
// the input stage register into the result buffer, behind any result there
// a byte that makes two results (value then byte or terminator) needs the
// two-entry result buffer empty after the pop, else the input waits
// synchronous active-low reset: decoder ended, input and result buffers empty
// a stalled output fills the buffer, then holds the input stage and ready
module quoted_string_unescape_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    qsu_in_if.sink     i_in,
    qsu_out_if.source  o_out
);
    import qsu_pkg::*;

    // input stage
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_open;

    // decoder state
    t_mode      r_mode, n_mode;
    logic [8:0] r_val, n_val;
    logic [1:0] r_cnt, n_cnt;

    // result buffer
    t_res       r_ob [2];
    t_res       n_ob [2];
    logic [1:0] r_ocnt, n_ocnt;

    logic       pop;
    logic       consume;
    logic [1:0] c_after;
    logic [1:0] res_n;
    t_res       res0, res1;
    logic [1:0] push_n;

    logic [7:0] b;
    logic       is_oct;
    logic [8:0] oct_val;
    logic [1:0] oct_cnt;
    logic [4:0] hexd;
    logic [8:0] hex_val;
    logic [1:0] hex_cnt;
    t_plain     pl;

    assign b       = r_in_byte;
    assign is_oct  = (b >= CH_0) && (b <= CH_7);
    assign oct_val = {r_val[5:0], b[2:0]};
    assign oct_cnt = r_cnt + 2'd1;
    assign hexd    = hex_digit(b);
    assign hex_val = {r_val[4:0], hexd[3:0]};
    assign hex_cnt = r_cnt + 2'd1;
    assign pl      = plain_emit(b);

    // next decoder state
    always_comb begin
        n_mode = r_mode;
        n_val  = r_val;
        n_cnt  = r_cnt;
        if (r_in_open) begin
            n_mode = MODE_NORMAL;
            n_val  = '0;
            n_cnt  = '0;
        end else begin
            case (r_mode)
                MODE_NORMAL: begin
                    n_mode = plain_mode(b);
                end
                MODE_ESC: begin
                    n_mode = MODE_NORMAL;
                    case (b) inside
                        CH_0: begin
                            n_mode = MODE_ZERO;
                            n_val  = '0;
                            n_cnt  = 2'd1;
                        end
                        [CH_1:CH_7]: begin
                            n_mode = MODE_OCT;
                            n_val  = {6'd0, b[2:0]};
                            n_cnt  = 2'd1;
                        end
                        CH_X_LO: begin
                            n_mode = MODE_HEX;
                            n_val  = '0;
                            n_cnt  = '0;
                        end
                        CH_NUL: begin
                            n_mode = MODE_ENDED;
                        end
                        default: begin
                            n_mode = MODE_NORMAL;
                        end
                    endcase
                end
                MODE_ZERO, MODE_OCT: begin
                    if (r_mode == MODE_ZERO && b == CH_X_LO) begin
                        n_mode = MODE_HEX;
                        n_val  = '0;
                        n_cnt  = '0;
                    end else if (is_oct) begin
                        if (oct_cnt >= OCT_DIGITS) begin
                            n_mode = MODE_NORMAL;
                            n_val  = '0;
                            n_cnt  = '0;
                        end else begin
                            n_mode = MODE_OCT;
                            n_val  = oct_val;
                            n_cnt  = oct_cnt;
                        end
                    end else begin
                        n_mode = plain_mode(b);
                        n_val  = '0;
                        n_cnt  = '0;
                    end
                end
                MODE_HEX: begin
                    if (hexd[4]) begin
                        if (hex_cnt >= HEX_DIGITS) begin
                            n_mode = MODE_NORMAL;
                            n_val  = '0;
                            n_cnt  = '0;
                        end else begin
                            n_val = hex_val;
                            n_cnt = hex_cnt;
                        end
                    end else begin
                        n_mode = plain_mode(b);
                        n_val  = '0;
                        n_cnt  = '0;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // results of the held byte
    always_comb begin
        res_n = 2'd0;
        res0  = '0;
        res1  = '0;
        if (!r_in_open) begin
            case (r_mode)
                MODE_NORMAL: begin
                    if (pl.emit) begin
                        res_n              = 2'd1;
                        res0.out_byte      = pl.out_byte;
                        res0.end_of_string = pl.end_of_string;
                    end
                end
                MODE_ESC: begin
                    res_n = 2'd1;
                    case (b) inside
                        CH_N_LO:  res0.out_byte = CH_LF;
                        CH_B_LO:  res0.out_byte = CH_BS;
                        CH_R_LO:  res0.out_byte = CH_CR;
                        CH_T_LO:  res0.out_byte = CH_TAB;
                        CH_F_LO:  res0.out_byte = CH_FF;
                        [CH_0:CH_7], CH_X_LO, CH_LF: res_n = 2'd0;
                        CH_NUL:   res0.end_of_string = 1'b1;
                        default:  res0.out_byte = b;
                    endcase
                end
                MODE_ZERO, MODE_OCT: begin
                    if (r_mode == MODE_ZERO && b == CH_X_LO) begin
                        res_n = 2'd0;
                    end else if (is_oct) begin
                        if (oct_cnt >= OCT_DIGITS) begin
                            res_n         = 2'd1;
                            res0.out_byte = oct_val[7:0];
                        end
                    end else begin
                        res_n              = pl.emit ? 2'd2 : 2'd1;
                        res0.out_byte      = r_val[7:0];
                        res1.out_byte      = pl.out_byte;
                        res1.end_of_string = pl.end_of_string;
                    end
                end
                MODE_HEX: begin
                    if (hexd[4]) begin
                        if (hex_cnt >= HEX_DIGITS) begin
                            res_n         = 2'd1;
                            res0.out_byte = hex_val[7:0];
                        end
                    end else begin
                        res_n              = pl.emit ? 2'd2 : 2'd1;
                        res0.out_byte      = r_val[7:0];
                        res1.out_byte      = pl.out_byte;
                        res1.end_of_string = pl.end_of_string;
                    end
                end
                default: begin
                    res_n = 2'd0;
                end
            endcase
        end
        res0.last_result = (res_n == 2'd1);
        res1.last_result = 1'b1;
    end

    // buffer space and handshakes
    assign pop        = (r_ocnt != 2'd0) && o_out.ready;
    assign c_after    = r_ocnt - {1'b0, pop};
    assign consume    = r_in_vld && ({1'b0, res_n} + {1'b0, c_after} <= 3'd2);
    assign push_n     = consume ? res_n : 2'd0;
    assign i_in.ready = !r_in_vld || consume;

    // result buffer next value
    always_comb begin
        n_ob[0] = pop ? r_ob[1] : r_ob[0];
        n_ob[1] = r_ob[1];
        if (push_n == 2'd2) begin
            n_ob[0] = res0;
            n_ob[1] = res1;
        end else if (push_n == 2'd1) begin
            if (c_after == 2'd0) begin
                n_ob[0] = res0;
            end else begin
                n_ob[1] = res0;
            end
        end
        n_ocnt = c_after + push_n;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= MODE_ENDED;
            r_val    <= '0;
            r_cnt    <= '0;
            r_ocnt   <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (consume) begin
                r_in_vld <= 1'b0;
            end
            if (consume) begin
                r_mode <= n_mode;
                r_val  <= n_val;
                r_cnt  <= n_cnt;
            end
            r_ocnt <= n_ocnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_open <= i_in.is_opening;
        end
        r_ob[0] <= n_ob[0];
        r_ob[1] <= n_ob[1];
    end

    // output side
    assign o_out.valid         = (r_ocnt != 2'd0);
    assign o_out.out_byte      = r_ob[0].out_byte;
    assign o_out.end_of_string = r_ob[0].end_of_string;
    assign o_out.last_result   = r_ob[0].last_result;

    // buffer never holds more than two results
    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("result buffer overfilled");

    // a lone buffered result must close its byte
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt == 2'd1 |-> r_ob[0].last_result)
        else $error("buffered result not marked last");

    // terminator is always the last result of its byte
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.end_of_string |-> o_out.last_result)
        else $error("terminator not last");

    // a pair of results only enters an empty buffer
    a_pair_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_n == 2'd2 |-> c_after == 2'd0)
        else $error("pair pushed without room");

endmodule
`default_nettype wire

@@ test/quoted_string_unescape_core_tb.sv @@
`timescale 1ns / 100ps
module quoted_string_unescape_core_tb;
    import qsu_pkg::*;

    // one raw item as queued for the driver
    typedef struct packed {
        logic [7:0] raw;
        logic       opening;
    } t_raw;

    typedef enum int {
        TOK_PLAIN,
        TOK_ESC,
        TOK_LITERAL,
        TOK_OCT,
        TOK_ZERO_OCT,
        TOK_HEX,
        TOK_ZERO_HEX
    } t_tok;

    typedef enum int {
        END_QUOTE,
        END_NUL,
        END_ESC_NUL,
        END_NONE
    } t_end;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_LONG,
        STALL_SPARSE
    } t_stall;

    localparam int LIVE_TARGET  = 1550;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = '0;
    logic       in_open   = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_taken  = 1'b0;

    qsu_in_if  in_if ();
    qsu_out_if out_if ();

    assign in_if.valid      = in_valid;
    assign in_if.in_byte    = in_byte;
    assign in_if.is_opening = in_open;
    assign out_if.ready     = out_ready;

    quoted_string_unescape_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder shadow state
    t_mode      dec_mode = MODE_ENDED;
    logic [8:0] num_acc  = '0;
    logic [1:0] num_cnt  = '0;

    t_res decoded_q[$];
    t_res step_res[$];
    t_raw raw_q[$];

    int n_live     = 0;
    int n_strings  = 0;
    int n_taken    = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int idle_count = 0;
    int burst_left = 1;
    int gap_left   = 0;
    int phase_left = 0;
    int hold_left  = 0;
    t_stall stall_kind = STALL_NONE;

    task automatic note_failure(input string text);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s", text);
        end
    endtask

    function automatic void add_result(input logic [7:0] b, input logic eos);
        t_res r;
        r.out_byte      = b;
        r.end_of_string = eos;
        r.last_result   = 1'b0;
        step_res.push_back(r);
    endfunction

    // ordinary byte inside the string
    function automatic void take_plain(input logic [7:0] b);
        if (b == CH_NUL || b == CH_QUOTE) begin
            add_result(CH_NUL, 1'b1);
            dec_mode = MODE_ENDED;
        end else if (b == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            add_result(b, 1'b0);
        end
    endfunction

    function automatic int hex_value(input logic [7:0] b);
        if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
        if (b >= CH_A_LO && b <= CH_F_LO) return int'(b - CH_A_LO) + 10;
        if (b >= CH_A_UP && b <= CH_F_UP) return int'(b - CH_A_UP) + 10;
        return -1;
    endfunction

    function automatic void restart_num(input t_mode m, input logic [8:0] v,
                                        input logic [1:0] c);
        dec_mode = m;
        num_acc  = v;
        num_cnt  = c;
    endfunction

    // expected results of one accepted raw byte
    function automatic void decode_byte(input logic [7:0] b, input logic opening);
        int   d;
        t_res r;
        step_res.delete();
        if (opening) begin
            restart_num(MODE_NORMAL, '0, '0);
        end else begin
            case (dec_mode)
                MODE_NORMAL: begin
                    take_plain(b);
                end
                MODE_ESC: begin
                    dec_mode = MODE_NORMAL;
                    case (b)
                        CH_N_LO:   add_result(CH_LF, 1'b0);
                        CH_B_LO:   add_result(CH_BS, 1'b0);
                        CH_R_LO:   add_result(CH_CR, 1'b0);
                        CH_T_LO:   add_result(CH_TAB, 1'b0);
                        CH_F_LO:   add_result(CH_FF, 1'b0);
                        CH_0:      restart_num(MODE_ZERO, '0, 2'd1);
                        CH_X_LO:   restart_num(MODE_HEX, '0, '0);
                        CH_LF:     ;
                        CH_NUL: begin
                            add_result(CH_NUL, 1'b1);
                            dec_mode = MODE_ENDED;
                        end
                        default: begin
                            if (b >= CH_1 && b <= CH_7) begin
                                restart_num(MODE_OCT, {6'd0, b[2:0]}, 2'd1);
                            end else begin
                                add_result(b, 1'b0);
                            end
                        end
                    endcase
                end
                MODE_ZERO, MODE_OCT: begin
                    if (dec_mode == MODE_ZERO && b == CH_X_LO) begin
                        restart_num(MODE_HEX, '0, '0);
                    end else begin
                        dec_mode = MODE_OCT;
                        if (b >= CH_0 && b <= CH_7) begin
                            num_acc = {num_acc[5:0], b[2:0]};
                            num_cnt = num_cnt + 2'd1;
                            if (num_cnt >= OCT_DIGITS) begin
                                add_result(num_acc[7:0], 1'b0);
                                restart_num(MODE_NORMAL, '0, '0);
                            end
                        end else begin
                            add_result(num_acc[7:0], 1'b0);
                            restart_num(MODE_NORMAL, '0, '0);
                            take_plain(b);
                        end
                    end
                end
                MODE_HEX: begin
                    d = hex_value(b);
                    if (d >= 0) begin
                        num_acc = {num_acc[4:0], 4'(d)};
                        num_cnt = num_cnt + 2'd1;
                        if (num_cnt >= HEX_DIGITS) begin
                            add_result(num_acc[7:0], 1'b0);
                            restart_num(MODE_NORMAL, '0, '0);
                        end
                    end else begin
                        add_result(num_acc[7:0], 1'b0);
                        restart_num(MODE_NORMAL, '0, '0);
                        take_plain(b);
                    end
                end
                default: ;
            endcase
        end
        // flag the final result of this byte
        if (step_res.size() > 0) begin
            r = step_res.pop_back();
            r.last_result = 1'b1;
            step_res.push_back(r);
        end
        while (step_res.size() > 0) begin
            decoded_q.push_back(step_res.pop_front());
        end
    endfunction

    // stimulus building
    function automatic void queue_raw(input logic [7:0] b, input logic op,
                                      input bit live = 1'b1);
        t_raw it;
        it.raw     = b;
        it.opening = op;
        raw_q.push_back(it);
        if (live) n_live++;
    endfunction

    function automatic logic [7:0] pick_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'(CH_0 + r);
        if (r < 16) return 8'(CH_A_LO + r - 10);
        return 8'(CH_A_UP + r - 16);
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = 8'(CH_A_LO + $urandom_range(0, 25));
        return b;
    endfunction

    function automatic t_tok pick_tok();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0, 1, 2, 3: return TOK_PLAIN;
            4, 5:       return TOK_ESC;
            6:          return TOK_LITERAL;
            7:          return TOK_OCT;
            8:          return TOK_ZERO_OCT;
            9, 10:      return TOK_HEX;
            default:    return TOK_ZERO_HEX;
        endcase
    endfunction

    function automatic t_end pick_end();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return END_QUOTE;
        if (r < 8) return END_NUL;
        if (r < 9) return END_ESC_NUL;
        return END_NONE;
    endfunction

    // one string with random escapes and a random end, then a little noise
    function automatic void queue_string();
        logic [7:0] esc_set[8];
        int   ntok;
        int   ndig;
        t_end fin;
        esc_set = '{CH_N_LO, CH_B_LO, CH_R_LO, CH_T_LO, CH_F_LO, CH_QUOTE, CH_BSLASH, CH_LF};
        n_strings++;
        queue_raw(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_QUOTE, 1'b1);
        ntok = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 10);
        for (int t = 0; t < ntok; t++) begin
            ndig = $urandom_range(0, 2);
            case (pick_tok())
                TOK_PLAIN: queue_raw(pick_plain(), 1'b0);
                TOK_ESC: begin
                    queue_raw(CH_BSLASH, 1'b0);
                    queue_raw(esc_set[$urandom_range(0, 7)], 1'b0);
                end
                TOK_LITERAL: begin
                    queue_raw(CH_BSLASH, 1'b0);
                    queue_raw(8'($urandom_range(0, 255)), 1'b0);
                end
                TOK_OCT: begin
                    queue_raw(CH_BSLASH, 1'b0);
                    queue_raw(8'(CH_1 + $urandom_range(0, 6)), 1'b0);
                    for (int k = 0; k < ndig; k++) queue_raw(8'(CH_0 + $urandom_range(0, 7)), 1'b0);
                end
                TOK_ZERO_OCT: begin
                    queue_raw(CH_BSLASH, 1'b0);
                    queue_raw(CH_0, 1'b0);
                    for (int k = 0; k < ndig; k++) queue_raw(8'(CH_0 + $urandom_range(0, 7)), 1'b0);
                end
                TOK_HEX: begin
                    queue_raw(CH_BSLASH, 1'b0);
                    queue_raw(CH_X_LO, 1'b0);
                    for (int k = 0; k < ndig; k++) queue_raw(pick_hex_char(), 1'b0);
                end
                default: begin
                    queue_raw(CH_BSLASH, 1'b0);
                    queue_raw(CH_0, 1'b0);
                    queue_raw(CH_X_LO, 1'b0);
                    for (int k = 0; k < ndig; k++) queue_raw(pick_hex_char(), 1'b0);
                end
            endcase
        end
        fin = pick_end();
        case (fin)
            END_QUOTE: queue_raw(CH_QUOTE, 1'b0);
            END_NUL:   queue_raw(CH_NUL, 1'b0);
            END_ESC_NUL: begin
                queue_raw(CH_BSLASH, 1'b0);
                queue_raw(CH_NUL, 1'b0);
            end
            default: begin
                // next opening cuts in, sometimes right after a backslash
                if ($urandom_range(0, 1) == 1) queue_raw(CH_BSLASH, 1'b0);
            end
        endcase
        // bytes after the terminator are dropped by the block
        if (fin != END_NONE) begin
            for (int k = $urandom_range(0, 3); k > 0; k--) begin
                queue_raw(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
        end
    endfunction

    // driver: bursts with random gaps, items change on the falling edge
    always @(negedge i_clk) begin
        logic       v;
        logic [7:0] b;
        logic       op;
        t_raw       it;
        v  = in_valid;
        b  = in_byte;
        op = in_open;
        if (!i_rst_n) begin
            v = 1'b0;
        end else if (!in_valid || in_taken) begin
            v = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (raw_q.size() > 0) begin
                it = raw_q.pop_front();
                v  = 1'b1;
                b  = it.raw;
                op = it.opening;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        in_valid <= v;
        in_byte  <= b;
        in_open  <= op;
    end

    // receiver: stall pattern switches between a few kinds
    always @(negedge i_clk) begin
        logic r;
        if (phase_left == 0) begin
            stall_kind = t_stall'($urandom_range(0, 3));
            phase_left = $urandom_range(20, 300);
        end else begin
            phase_left--;
        end
        case (stall_kind)
            STALL_NONE: r = 1'b1;
            STALL_COIN: r = 1'($urandom_range(0, 1));
            STALL_LONG: begin
                if (hold_left > 0) begin
                    r = 1'b0;
                    hold_left--;
                end else begin
                    r = 1'b1;
                    if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 20);
                end
            end
            default: r = ($urandom_range(0, 2) == 0);
        endcase
        out_ready <= r;
    end

    // monitor: predict on input items, check output items, watchdog
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            in_taken   <= 1'b0;
            idle_count = 0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.in_byte, in_if.is_opening);
                n_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                got.out_byte      = out_if.out_byte;
                got.end_of_string = out_if.end_of_string;
                got.last_result   = out_if.last_result;
                if (decoded_q.size() == 0) begin
                    note_failure($sformatf("unexpected item: byte=%02h eos=%b last=%b",
                                           got.out_byte, got.end_of_string, got.last_result));
                end else begin
                    want = decoded_q.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        note_failure($sformatf(
                            "mismatch #%0d: exp byte=%02h eos=%b last=%b, got byte=%02h eos=%b last=%b",
                            n_checked, want.out_byte, want.end_of_string, want.last_result,
                            got.out_byte, got.end_of_string, got.last_result));
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_count = 0;
            end else begin
                idle_count++;
            end
            if (idle_count >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        // directed: ended bytes, extremes, several escape forms and repair cases
        queue_raw(CH_A_UP, 1'b0, 1'b0);
        queue_raw(CH_QUOTE, 1'b1);
        queue_raw(8'hFF, 1'b0);
        queue_raw(8'h01, 1'b0);
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(CH_N_LO, 1'b0);
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(CH_0, 1'b0);
        queue_raw(CH_X_LO, 1'b0);
        queue_raw(8'h34, 1'b0);
        queue_raw(CH_F_UP, 1'b0);
        // octal overflow
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(CH_7, 1'b0);
        queue_raw(CH_7, 1'b0);
        queue_raw(CH_7, 1'b0);
        // hex with no digit, then 'g'
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(CH_X_LO, 1'b0);
        queue_raw(8'h67, 1'b0);
        // backslash-newline
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(CH_LF, 1'b0);
        // value ended by the closing quote
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(8'h33, 1'b0);
        queue_raw(CH_QUOTE, 1'b0);
        queue_raw(8'h7A, 1'b0, 1'b0);
        // opening mid-escape, then backslash before a zero byte
        queue_raw(8'h80, 1'b1);
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(CH_QUOTE, 1'b1);
        queue_raw(CH_BSLASH, 1'b0);
        queue_raw(CH_NUL, 1'b0);
        n_strings = 3;
        while (n_live < LIVE_TARGET) begin
            queue_string();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(raw_q.size() == 0 && !in_valid && decoded_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            note_failure($sformatf("%0d expected items never arrived", decoded_q.size()));
        end

        $display("covered %0d strings, %0d raw bytes accepted, %0d decoded items checked",
                 n_strings, n_taken, n_checked);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/qsu_pkg.sv
rtl/qsu_if.sv
rtl/quoted_string_unescape_core.sv
test/quoted_string_unescape_core_tb.sv
